// ----- sv/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, constants and types of the RGB / HSV / HSL color converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CH_BITS     = 8;
   localparam int HUE_IN_BITS = 16;
   localparam int HUE_BITS    = 15;
   localparam int FRAC_BITS   = 6;

   localparam int CH_MAX   = (1 << CH_BITS) - 1;
   localparam int SEG      = 60 << FRAC_BITS;
   localparam int HUE_FULL = 360 << FRAC_BITS;
   localparam int DEN_HSV  = CH_MAX * SEG;
   localparam int DEN_HSL  = CH_MAX * CH_MAX * SEG;

   // Divider lanes: numerator, divisor and quotient widths.
   localparam int LANES = 3;
   localparam int NW    = 28;
   localparam int DW    = 28;
   localparam int QW    = 15;
   localparam int SW    = DW + QW;

   typedef enum logic [1:0] {
      MODE_RGB_HSV = 2'd0,
      MODE_RGB_HSL = 2'd1,
      MODE_HSV_RGB = 2'd2,
      MODE_HSL_RGB = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2
   } hue_sel_type;

   typedef struct packed {
      mode_type                  mode;
      logic [CH_BITS-1:0]        level;
      logic [2:0]                sector;
      logic                      gray;
   } side_type;

   typedef struct packed {
      side_type                  side;
      logic [LANES-1:0][NW-1:0]  rem;
      logic [LANES-1:0][DW-1:0]  dvs;
      logic [LANES-1:0][QW-1:0]  quo;
   } div_word_type;

endpackage

// ----- sv/rhc_front.sv -----
// ----------------------------------------------------------------------------
// rhc_front
// Two pipeline stages that turn a pixel into three divider lanes.
// ----------------------------------------------------------------------------
module rhc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  rhc_pkg::mode_type                mode,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rhc_pkg::CH_BITS-1:0]      in_red,
   input  logic [rhc_pkg::CH_BITS-1:0]      in_green,
   input  logic [rhc_pkg::CH_BITS-1:0]      in_blue,
   input  logic [rhc_pkg::HUE_IN_BITS-1:0]  in_hue,
   input  logic [rhc_pkg::CH_BITS-1:0]      in_saturation,
   input  logic [rhc_pkg::CH_BITS-1:0]      in_level,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rhc_pkg::div_word_type            out_word
);
   import rhc_pkg::*;

   typedef struct packed {
      mode_type            mode;
      logic [CH_BITS-1:0]  red;
      logic [CH_BITS-1:0]  green;
      logic [CH_BITS-1:0]  blue;
      logic [CH_BITS-1:0]  mx;
      logic [CH_BITS-1:0]  delta;
      logic [CH_BITS:0]    sum;
      hue_sel_type         sel;
      logic [HUE_BITS-1:0] hm;
      logic [2:0]          sector;
      logic [11:0]         t;
      logic [CH_BITS-1:0]  sat;
      logic [CH_BITS-1:0]  lv;
      logic [15:0]         ls;
      logic [15:0]         q;
   } stage_a_type;

   function automatic logic [11:0] hsl_weight(input logic [HUE_BITS-1:0] tt);
      logic [11:0] w;
      if (tt < HUE_BITS'(SEG)) begin
         w = 12'(tt);
      end else if (tt < HUE_BITS'(3 * SEG)) begin
         w = 12'(SEG);
      end else if (tt < HUE_BITS'(4 * SEG)) begin
         w = 12'(HUE_BITS'(4 * SEG) - tt);
      end else begin
         w = 12'd0;
      end
      return w;
   endfunction

   function automatic logic [HUE_BITS-1:0] hue_shift(input logic [HUE_BITS-1:0] hh,
                                                     input logic [15:0] off);
      logic [15:0] s;
      s = 16'(hh) + off;
      if (s >= 16'(HUE_FULL)) begin
         s = s - 16'(HUE_FULL);
      end
      return s[HUE_BITS-1:0];
   endfunction

   stage_a_type   a_in, a_ff;
   logic          a_valid_ff, a_ready;
   div_word_type  b_in, b_ff;
   logic          b_valid_ff, b_ready;

   logic [CH_BITS-1:0]  mx, mn;
   logic [15:0]         hm16;
   logic [11:0]         f;
   logic [HUE_BITS-1:0] base;

   always_comb begin
      mx = in_red;
      if (in_green > mx) mx = in_green;
      if (in_blue > mx) mx = in_blue;
      mn = in_red;
      if (in_green < mn) mn = in_green;
      if (in_blue < mn) mn = in_blue;

      a_in.mode  = mode;
      a_in.red   = in_red;
      a_in.green = in_green;
      a_in.blue  = in_blue;
      a_in.mx    = mx;
      a_in.delta = mx - mn;
      a_in.sum   = {1'b0, mx} + {1'b0, mn};
      if (mx == in_red) begin
         a_in.sel = SEL_RED;
      end else if (mx == in_green) begin
         a_in.sel = SEL_GREEN;
      end else begin
         a_in.sel = SEL_BLUE;
      end

      if (in_hue >= 16'(2 * HUE_FULL)) begin
         hm16 = in_hue - 16'(2 * HUE_FULL);
      end else if (in_hue >= 16'(HUE_FULL)) begin
         hm16 = in_hue - 16'(HUE_FULL);
      end else begin
         hm16 = in_hue;
      end
      a_in.hm = hm16[HUE_BITS-1:0];

      if (a_in.hm >= HUE_BITS'(5 * SEG)) a_in.sector = 3'd5;
      else if (a_in.hm >= HUE_BITS'(4 * SEG)) a_in.sector = 3'd4;
      else if (a_in.hm >= HUE_BITS'(3 * SEG)) a_in.sector = 3'd3;
      else if (a_in.hm >= HUE_BITS'(2 * SEG)) a_in.sector = 3'd2;
      else if (a_in.hm >= HUE_BITS'(SEG)) a_in.sector = 3'd1;
      else a_in.sector = 3'd0;
      base   = HUE_BITS'(SEG) * {12'd0, a_in.sector};
      f      = 12'(a_in.hm - base);
      a_in.t = a_in.sector[0] ? 12'(SEG) - f : f;

      a_in.sat = in_saturation;
      a_in.lv  = in_level;
      a_in.ls  = 16'(in_level) * 16'(in_saturation);
      if ({1'b0, in_level, 1'b0} < 10'(CH_MAX)) begin
         a_in.q = 16'(in_level) * (16'(CH_MAX) + 16'(in_saturation));
      end else begin
         a_in.q = (16'(in_level) + 16'(in_saturation)) * 16'(CH_MAX) - a_in.ls;
      end
   end

   assign a_ready = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_ff <= a_in;
      end
   end

   logic [15:0]         p, qp;
   logic [9:0]          g_num;
   logic [10:0]         b_num;
   logic [CH_BITS:0]    sden;
   logic [HUE_BITS-1:0] t_lane [LANES];

   always_comb begin
      b_in.side.mode   = a_ff.mode;
      b_in.side.level  = a_ff.lv;
      b_in.side.sector = a_ff.sector;
      b_in.side.gray   = (a_ff.sat == '0);
      b_in.quo         = '0;
      for (int i = 0; i < LANES; i++) begin
         b_in.rem[i] = '0;
         b_in.dvs[i] = DW'(1);
      end

      p      = 16'({a_ff.lv, 1'b0}) * 16'(CH_MAX) - a_ff.q;
      qp     = a_ff.q - p;
      g_num  = 10'(a_ff.blue) + 10'({a_ff.delta, 1'b0}) - 10'(a_ff.red);
      b_num  = 11'(a_ff.red) + 11'({a_ff.delta, 2'b00}) - 11'(a_ff.green);
      sden   = (a_ff.sum <= 9'(CH_MAX)) ? a_ff.sum : 9'(2 * CH_MAX) - a_ff.sum;
      t_lane[0] = hue_shift(a_ff.hm, 16'(2 * SEG));
      t_lane[1] = a_ff.hm;
      t_lane[2] = hue_shift(a_ff.hm, 16'(4 * SEG));

      unique case (a_ff.mode)
         MODE_RGB_HSV, MODE_RGB_HSL: begin
            if (a_ff.mode == MODE_RGB_HSV) begin
               b_in.side.level = a_ff.mx;
            end else begin
               b_in.side.level = a_ff.sum[CH_BITS:1];
            end
            if (a_ff.delta != '0) begin
               b_in.dvs[0] = DW'(a_ff.delta);
               unique case (a_ff.sel)
                  SEL_RED: begin
                     if (a_ff.green >= a_ff.blue) begin
                        b_in.rem[0] = NW'(a_ff.green - a_ff.blue) * NW'(SEG);
                     end else begin
                        b_in.rem[0] = NW'(a_ff.delta) * NW'(HUE_FULL)
                                    - NW'(a_ff.blue - a_ff.green) * NW'(SEG);
                     end
                  end
                  SEL_GREEN: b_in.rem[0] = NW'(g_num) * NW'(SEG);
                  default:   b_in.rem[0] = NW'(b_num) * NW'(SEG);
               endcase
               b_in.rem[1] = NW'(a_ff.delta) * NW'(CH_MAX);
               if (a_ff.mode == MODE_RGB_HSV) begin
                  b_in.dvs[1] = DW'(a_ff.mx);
               end else begin
                  b_in.dvs[1] = DW'(sden);
               end
            end
         end
         MODE_HSV_RGB: begin
            b_in.rem[1] = NW'(a_ff.lv) * NW'(CH_MAX) - NW'(a_ff.ls);
            b_in.dvs[1] = DW'(CH_MAX);
            b_in.rem[2] = NW'(a_ff.lv) * NW'(DEN_HSV)
                        - NW'(a_ff.ls) * NW'(12'(SEG) - a_ff.t);
            b_in.dvs[2] = DW'(DEN_HSV);
         end
         default: begin
            for (int i = 0; i < LANES; i++) begin
               b_in.rem[i] = NW'(p) * NW'(SEG) + NW'(qp) * NW'(hsl_weight(t_lane[i]));
               b_in.dvs[i] = DW'(DEN_HSL);
            end
         end
      endcase
   end

   assign b_ready = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_ff;

endmodule

// ----- sv/rhc_div_stage.sv -----
// ----------------------------------------------------------------------------
// rhc_div_stage
// One restoring-division step: settles quotient bit BIT in all three lanes.
// ----------------------------------------------------------------------------
module rhc_div_stage #(
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rhc_pkg::div_word_type  in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rhc_pkg::div_word_type  out_word
);
   import rhc_pkg::*;

   div_word_type word_in, word_ff;
   logic         valid_ff;
   logic [SW-1:0] shifted [LANES];

   always_comb begin
      word_in = in_word;
      for (int i = 0; i < LANES; i++) begin
         shifted[i] = SW'(in_word.dvs[i]) << BIT;
         if (SW'(in_word.rem[i]) >= shifted[i]) begin
            word_in.rem[i]      = in_word.rem[i] - shifted[i][NW-1:0];
            word_in.quo[i][BIT] = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- sv/rhc_back.sv -----
// ----------------------------------------------------------------------------
// rhc_back
// Maps the lane quotients onto the result fields and holds the result word.
// ----------------------------------------------------------------------------
module rhc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rhc_pkg::div_word_type         in_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rhc_pkg::CH_BITS-1:0]   rsp_out_red,
   output logic [rhc_pkg::CH_BITS-1:0]   rsp_out_green,
   output logic [rhc_pkg::CH_BITS-1:0]   rsp_out_blue,
   output logic [rhc_pkg::HUE_BITS-1:0]  rsp_out_hue,
   output logic [rhc_pkg::CH_BITS-1:0]   rsp_out_saturation,
   output logic [rhc_pkg::CH_BITS-1:0]   rsp_out_level
);
   import rhc_pkg::*;

   logic [CH_BITS-1:0]  red_in, green_in, blue_in, sat_in, level_in;
   logic [CH_BITS-1:0]  red_ff, green_ff, blue_ff, sat_ff, level_ff;
   logic [HUE_BITS-1:0] hue_in, hue_ff;
   logic [CH_BITS-1:0]  full, low, mid;
   logic                valid_ff;

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      hue_in   = '0;
      sat_in   = '0;
      level_in = '0;
      full     = in_word.side.level;
      low      = in_word.quo[1][CH_BITS-1:0];
      mid      = in_word.quo[2][CH_BITS-1:0];
      unique case (in_word.side.mode)
         MODE_RGB_HSV, MODE_RGB_HSL: begin
            hue_in   = in_word.quo[0][HUE_BITS-1:0];
            sat_in   = in_word.quo[1][CH_BITS-1:0];
            level_in = in_word.side.level;
         end
         MODE_HSV_RGB: begin
            case (in_word.side.sector)
               3'd0: begin red_in = full; green_in = mid;  blue_in = low;  end
               3'd1: begin red_in = mid;  green_in = full; blue_in = low;  end
               3'd2: begin red_in = low;  green_in = full; blue_in = mid;  end
               3'd3: begin red_in = low;  green_in = mid;  blue_in = full; end
               3'd4: begin red_in = mid;  green_in = low;  blue_in = full; end
               default: begin red_in = full; green_in = low; blue_in = mid; end
            endcase
         end
         default: begin
            if (in_word.side.gray) begin
               red_in   = in_word.side.level;
               green_in = in_word.side.level;
               blue_in  = in_word.side.level;
            end else begin
               red_in   = in_word.quo[0][CH_BITS-1:0];
               green_in = in_word.quo[1][CH_BITS-1:0];
               blue_in  = in_word.quo[2][CH_BITS-1:0];
            end
         end
      endcase
   end

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         level_ff <= level_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_red        = red_ff;
   assign rsp_out_green      = green_ff;
   assign rsp_out_blue       = blue_ff;
   assign rsp_out_hue        = hue_ff;
   assign rsp_out_saturation = sat_ff;
   assign rsp_out_level      = level_ff;

endmodule

// ----- sv/rgb_hsv_hsl_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_hsv_hsl_converter_core
// Pipelined pixel converter between RGB and HSV or HSL, direction by register.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid/req_ready    one input pixel word
//   rsp_      out        rsp_valid/rsp_ready    one converted pixel word
//   csr_      in         csr_wr_en              conversion mode, no read-back
//
// One word enters per cycle unless rsp_ready stalls; a word passes two setup
// stages, one stage per quotient bit of the 15-bit three-lane divider, and the
// output register. Every stage holds its own valid bit and moves on when the
// next stage is empty or moving, so a stall at rsp_ready fills bubbles first.
// Synchronous reset empties the pipeline and sets the mode to RGB to HSV.
// ----------------------------------------------------------------------------
module rgb_hsv_hsl_converter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [1:0]                       csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rhc_pkg::CH_BITS-1:0]      req_in_red,
   input  logic [rhc_pkg::CH_BITS-1:0]      req_in_green,
   input  logic [rhc_pkg::CH_BITS-1:0]      req_in_blue,
   input  logic [rhc_pkg::HUE_IN_BITS-1:0]  req_in_hue,
   input  logic [rhc_pkg::CH_BITS-1:0]      req_in_saturation,
   input  logic [rhc_pkg::CH_BITS-1:0]      req_in_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rhc_pkg::CH_BITS-1:0]      rsp_out_red,
   output logic [rhc_pkg::CH_BITS-1:0]      rsp_out_green,
   output logic [rhc_pkg::CH_BITS-1:0]      rsp_out_blue,
   output logic [rhc_pkg::HUE_BITS-1:0]     rsp_out_hue,
   output logic [rhc_pkg::CH_BITS-1:0]      rsp_out_saturation,
   output logic [rhc_pkg::CH_BITS-1:0]      rsp_out_level
);
   import rhc_pkg::*;

   mode_type     mode_ff;
   div_word_type word  [QW+1];
   logic         valid [QW+1];
   logic         ready [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RGB_HSV;
      end else if (csr_wr_en) begin
         mode_ff <= mode_type'(csr_wr_data);
      end
   end

   rhc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_red        (req_in_red),
      .in_green      (req_in_green),
      .in_blue       (req_in_blue),
      .in_hue        (req_in_hue),
      .in_saturation (req_in_saturation),
      .in_level      (req_in_level),
      .out_valid     (valid[0]),
      .out_ready     (ready[0]),
      .out_word      (word[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_div
      rhc_div_stage #(
         .BIT (QW - 1 - i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_word   (word[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_word  (word[i+1])
      );
   end

   rhc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (valid[QW]),
      .in_ready           (ready[QW]),
      .in_word            (word[QW]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_hue        (rsp_out_hue),
      .rsp_out_saturation (rsp_out_saturation),
      .rsp_out_level      (rsp_out_level)
   );

endmodule
